/* hw/rtl/dn_pkg.sv */
package dn_pkg;

  localparam int MAX_INDEX = 16;
  localparam int IDX_W     = 5;
  localparam int VAL_W     = 64;
  localparam int NUM_CELLS = MAX_INDEX + 1;
  localparam int CNT_W     = $clog2(2 * MAX_INDEX + 1);
  localparam int SEL_W     = $clog2(NUM_CELLS);
  localparam int IN_DATA_W = 16;

  // Control wave that travels along the cell chain, one cell per cycle.
  typedef struct packed {
    logic en;     // cell computes one table row in this cycle
    logic first;  // the row is row zero
  } wave_t;

  function automatic logic [IDX_W-1:0] clamp_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    res = (idx > IDX_W'(MAX_INDEX)) ? IDX_W'(MAX_INDEX) : idx;
    return res;
  endfunction

endpackage

/* hw/rtl/dn_cell.sv */
module dn_cell import dn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wave_t            wave_i,
  input  logic             force_one_i,
  input  logic [VAL_W-1:0] left_val_i,
  input  logic [VAL_W-1:0] left_prev_i,
  output wave_t            wave_o,
  output logic [VAL_W-1:0] val_o,
  output logic [VAL_W-1:0] prev_o
);

  wave_t            wave_q;
  logic [VAL_W-1:0] val_q, val_d;
  logic [VAL_W-1:0] prev_q;

  // The left neighbor holds this row's value and the row above it, which
  // is the diagonal term; val_q still holds the entry from the row above.
  always_comb begin
    if (wave_i.first || force_one_i) begin
      val_d = VAL_W'(1);
    end else begin
      val_d = val_q + left_prev_i + left_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q <= wave_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wave_i.en) begin
      prev_q <= val_q;
      val_q  <= val_d;
    end
  end

  assign wave_o = wave_q;
  assign val_o  = val_q;
  assign prev_o = prev_q;

endmodule

/* hw/rtl/delannoy_number.sv */
// Delannoy number engine: each input word carries indices m and n, each
// output word carries D(m,n) modulo 2^64. Indices above 16 are saturated
// to 16. The table is computed by a chain of 17 cells, one per column,
// with a row wavefront moving one cell per cycle; the result is taken
// from cell n into the output register once the count reaches m + n.
// One word is in work at a time; a new word is accepted as soon as the
// previous result sits in the output register, even while it waits there.
module delannoy_number import dn_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,   // [4:0] row_index, [9:5] col_index
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [VAL_W-1:0]     m_axis_tdata    // [63:0] value
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_LOAD
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] m_q, n_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic [VAL_W-1:0] out_data_q;

  wave_t            wave   [NUM_CELLS+1];
  logic [VAL_W-1:0] val    [NUM_CELLS];
  logic [VAL_W-1:0] prev   [NUM_CELLS];

  logic in_accept;
  logic load_out;
  logic [CNT_W-1:0] last_cnt;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign load_out      = (state_q == S_LOAD) && (!out_valid_q || m_axis_tready);
  assign last_cnt      = CNT_W'(m_q) + CNT_W'(n_q);

  // Row zero starts at cell zero on the first cycle; rows 1..m follow.
  assign wave[0].en    = (state_q == S_RUN) && (cnt_q <= CNT_W'(m_q));
  assign wave[0].first = (state_q == S_RUN) && (cnt_q == '0);

  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    logic [VAL_W-1:0] lv, lp;
    if (j == 0) begin : g_head
      assign lv = '0;
      assign lp = '0;
    end else begin : g_body
      assign lv = val[j-1];
      assign lp = prev[j-1];
    end
    dn_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wave_i      (wave[j]),
      .force_one_i (j == 0),
      .left_val_i  (lv),
      .left_prev_i (lp),
      .wave_o      (wave[j+1]),
      .val_o       (val[j]),
      .prev_o      (prev[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_RUN;
            cnt_q   <= '0;
          end
        end
        S_RUN: begin
          // Cell n takes row m in the cycle where the count reaches m + n.
          if (cnt_q == last_cnt) begin
            state_q <= S_LOAD;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_LOAD: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      m_q <= clamp_index(s_axis_tdata[IDX_W-1:0]);
      n_q <= clamp_index(s_axis_tdata[2*IDX_W-1:IDX_W]);
    end
    if (load_out) begin
      out_data_q <= val[n_q[SEL_W-1:0]];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_wave_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wave[0].en |-> (state_q == S_RUN))
    else $error("cell chain enabled outside a computation");

  a_load_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_axis_tvalid)
    else $error("result register loaded without raising valid");

  a_zero_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && (m_q == '0 || n_q == '0)) |=> (m_axis_tdata == VAL_W'(1)))
    else $error("zero index did not give one");

endmodule
